// ===== rtl/core/rhh_pkg.sv =====
// rhh_pkg: shared types and constants for the robin hood hash insert block
// sizes of the slot store, state machine states, result codes, control structs
// no dependencies
`default_nettype none

package rhh_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = IDX_W + 1;
   localparam int HASH_W      = 64;
   localparam int OFFSET_W    = 32;
   localparam int LOG2_W      = 4;
   localparam int REQ_DATA_W  = 96;
   localparam int RSP_DATA_W  = 40;

   localparam logic [LOG2_W-1:0] LOG2_MIN   = 4'd3;
   localparam logic [LOG2_W-1:0] LOG2_MAX   = 4'd10;
   localparam logic [LOG2_W-1:0] LOG2_RESET = 4'd10;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_CLEAR  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_PLACED  = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_ZERO    = 2'd2,
      STATUS_CLEARED = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_READ,
      ST_CHECK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [HASH_W-1:0]   hash;
      logic [OFFSET_W-1:0] offset;
      logic [CNT_W-1:0]    distance;
   } entry_type;

   typedef struct packed {
      logic load_item;
      logic clear_init;
      logic clear_write;
      logic issue_read;
      logic evaluate;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic is_clear;
      logic is_reject;
      logic probe_done;
      logic rsp_free;
   } stat_type;

endpackage

`default_nettype wire

// ===== rtl/core/robin_hood_hash_insert.sv =====
// robin_hood_hash_insert: top level of the robin hood hash insert block
// depends on rhh_pkg, rhh_ctrl and rhh_datapath
//
// Inserts a 64-bit key hash and a payload offset into a 1024-slot store by robin hood
// linear probing; a clear command or a csr write empties the store. Each insert visits
// its slots through the single memory port, a read and then a compare and swap per slot,
// between a load step and a result step; rejected inserts skip the probe. A clear, a
// csr write and reset each run a clearing pass over all 1024 slots of the store, during
// which no request is taken.
// One result per request; a finished result waits in an output register while the
// next request is accepted.
`default_nettype none

module robin_hood_hash_insert (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire [rhh_pkg::REQ_DATA_W-1:0]    req_tdata,  // key_hash, payload_offset
   input  wire                              req_tuser,  // command
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   // placed_slot, probe_count, entry_count, over_threshold, zero pad
   output logic [rhh_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [1:0]                       rsp_tuser,  // status
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire [rhh_pkg::LOG2_W-1:0]        csr_data    // log2_capacity
);
   import rhh_pkg::*;

   cmd_type          cmd;
   stat_type         stat;
   logic             req_fire;
   logic             csr_fire;
   logic [IDX_W-1:0] placed_slot;
   logic [CNT_W-1:0] probe_count;
   logic [CNT_W-1:0] entry_count;
   logic             over_threshold;

   assign req_fire = req_tvalid && req_tready;
   assign csr_fire = csr_valid && csr_ready;

   rhh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .csr_fire  (csr_fire),
      .stat      (stat),
      .cmd       (cmd),
      .req_ready (req_tready),
      .csr_ready (csr_ready)
   );

   rhh_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .csr_fire           (csr_fire),
      .csr_data           (csr_data),
      .item_command       (req_tuser),
      .item_hash          (req_tdata[HASH_W-1:0]),
      .item_offset        (req_tdata[HASH_W+OFFSET_W-1:HASH_W]),
      .rsp_valid          (rsp_tvalid),
      .rsp_ready          (rsp_tready),
      .rsp_status         (rsp_tuser),
      .rsp_placed_slot    (placed_slot),
      .rsp_probe_count    (probe_count),
      .rsp_entry_count    (entry_count),
      .rsp_over_threshold (over_threshold)
   );

   assign rsp_tdata = {7'd0, over_threshold, entry_count, probe_count, placed_slot};

endmodule

`default_nettype wire

// ===== rtl/core/rhh_ctrl.sv =====
// rhh_ctrl: sequencer for clearing passes and insert probe chains
// depends on rhh_pkg; drives rhh_datapath through cmd_type, reads stat_type
`default_nettype none

module rhh_ctrl (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_fire,
   input  wire                csr_fire,
   input  rhh_pkg::stat_type  stat,
   output rhh_pkg::cmd_type   cmd,
   output logic               req_ready,
   output logic               csr_ready
);
   import rhh_pkg::*;

   state_type state_ff, state_in;
   logic      pending_ff, pending_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         pending_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pending_ff <= pending_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      pending_in = pending_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (!csr_fire && stat.clear_last) begin
               state_in   = pending_ff ? ST_DONE : ST_IDLE;
               pending_in = 1'b0;
            end
         end
         ST_IDLE: begin
            if (csr_fire) state_in = ST_CLEAR;
            else if (req_fire) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (stat.is_clear) begin
               state_in   = ST_CLEAR;
               pending_in = 1'b1;
            end else if (stat.is_reject) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_READ:  state_in = ST_CHECK;
         ST_CHECK: state_in = stat.probe_done ? ST_DONE : ST_READ;
         ST_DONE:  if (stat.rsp_free) state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      req_ready       = (state_ff == ST_IDLE) && !csr_fire;
      csr_ready       = (state_ff == ST_IDLE) || ((state_ff == ST_CLEAR) && !pending_ff);
      cmd.load_item   = req_fire && !csr_fire;
      cmd.clear_init  = csr_fire || ((state_ff == ST_LOAD) && stat.is_clear);
      cmd.clear_write = (state_ff == ST_CLEAR) && !csr_fire;
      cmd.issue_read  = (state_ff == ST_READ);
      cmd.evaluate    = (state_ff == ST_CHECK);
      cmd.finish      = (state_ff == ST_DONE) && stat.rsp_free;
   end

endmodule

`default_nettype wire

// ===== rtl/core/rhh_datapath.sv =====
// rhh_datapath: slot store, carried entry, counters and result register
// depends on rhh_pkg; controlled by rhh_ctrl through cmd_type
`default_nettype none

module rhh_datapath (
   input  wire                                  clock,
   input  wire                                  reset,
   input  rhh_pkg::cmd_type                     cmd,
   output rhh_pkg::stat_type                    stat,
   input  wire                                  csr_fire,
   input  wire [rhh_pkg::LOG2_W-1:0]            csr_data,
   input  wire                                  item_command,
   input  wire [rhh_pkg::HASH_W-1:0]            item_hash,
   input  wire [rhh_pkg::OFFSET_W-1:0]          item_offset,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output logic [1:0]                           rsp_status,
   output logic [rhh_pkg::IDX_W-1:0]            rsp_placed_slot,
   output logic [rhh_pkg::CNT_W-1:0]            rsp_probe_count,
   output logic [rhh_pkg::CNT_W-1:0]            rsp_entry_count,
   output logic                                 rsp_over_threshold
);
   import rhh_pkg::*;

   entry_type mem [TABLE_DEPTH];
   entry_type rd_ff;

   logic [LOG2_W-1:0] log2_ff;
   logic [IDX_W-1:0]  clr_addr_ff;
   logic [CNT_W-1:0]  count_ff;
   status_type        status_ff;
   entry_type         carry_ff, carry_in;
   logic [IDX_W-1:0]  slot_ff;
   logic [CNT_W-1:0]  visits_ff;
   logic [IDX_W-1:0]  placed_ff;
   logic              first_ff;
   logic              rsp_valid_ff;
   status_type        rsp_status_ff;
   logic [IDX_W-1:0]  rsp_placed_ff;
   logic [CNT_W-1:0]  rsp_probe_ff;
   logic [CNT_W-1:0]  rsp_count_ff;
   logic              rsp_over_ff;

   logic [LOG2_W-1:0] lg;
   logic [CNT_W-1:0]  cap;
   logic [IDX_W-1:0]  mask;
   logic [CNT_W-1:0]  quarter;
   logic [CNT_W-1:0]  limit;
   logic [CNT_W-1:0]  count_next;
   logic [CNT_W-1:0]  visits_next;
   logic              swap;
   status_type        load_status;

   always_comb begin
      if (log2_ff < LOG2_MIN) lg = LOG2_MIN;
      else if (log2_ff > LOG2_MAX) lg = LOG2_MAX;
      else lg = log2_ff;
      cap     = CNT_W'(1) << lg;
      mask    = IDX_W'(cap - CNT_W'(1));
      quarter = cap >> 2;
      limit   = quarter + (quarter << 1);
   end

   always_comb begin
      priority if (item_command == CMD_CLEAR) load_status = STATUS_CLEARED;
      else if (item_hash == '0) load_status = STATUS_ZERO;
      else if (count_ff >= cap) load_status = STATUS_FULL;
      else load_status = STATUS_PLACED;
   end

   assign swap        = (rd_ff.hash == '0) || (carry_ff.distance > rd_ff.distance);
   assign visits_next = visits_ff + CNT_W'(1);
   assign carry_in    = swap ? rd_ff : carry_ff;
   assign count_next  = (status_ff == STATUS_PLACED) ? count_ff + CNT_W'(1) : count_ff;

   always_comb begin
      stat.clear_last = (clr_addr_ff == IDX_W'(TABLE_DEPTH - 1));
      stat.is_clear   = (status_ff == STATUS_CLEARED);
      stat.is_reject  = (status_ff == STATUS_ZERO) || (status_ff == STATUS_FULL);
      stat.probe_done = (carry_in.hash == '0) || (visits_next == cap);
      stat.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   // slot store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.clear_write) mem[clr_addr_ff] <= '0;
      else if (cmd.evaluate && swap) mem[slot_ff] <= carry_ff;
      if (cmd.issue_read) rd_ff <= mem[slot_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         log2_ff      <= LOG2_RESET;
         clr_addr_ff  <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_fire) log2_ff <= csr_data;
         if (cmd.clear_init) begin
            clr_addr_ff <= '0;
            count_ff    <= '0;
         end else if (cmd.clear_write) begin
            clr_addr_ff <= clr_addr_ff + IDX_W'(1);
         end else if (cmd.finish) begin
            count_ff <= count_next;
         end
         if (cmd.finish) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         status_ff         <= load_status;
         carry_ff.hash     <= item_hash;
         carry_ff.offset   <= item_offset;
         carry_ff.distance <= '0;
         slot_ff           <= IDX_W'(item_hash) & mask;
         visits_ff         <= '0;
         placed_ff         <= '0;
         first_ff          <= 1'b1;
      end else if (cmd.evaluate) begin
         carry_ff  <= '{hash: carry_in.hash, offset: carry_in.offset,
                        distance: carry_in.distance + CNT_W'(1)};
         slot_ff   <= (slot_ff + IDX_W'(1)) & mask;
         visits_ff <= visits_next;
         if (swap && first_ff) begin
            placed_ff <= slot_ff;
            first_ff  <= 1'b0;
         end
      end
      if (cmd.finish) begin
         rsp_status_ff <= status_ff;
         rsp_placed_ff <= placed_ff;
         rsp_probe_ff  <= visits_ff;
         rsp_count_ff  <= count_next;
         rsp_over_ff   <= (count_next > limit);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_placed_slot    = rsp_placed_ff;
   assign rsp_probe_count    = rsp_probe_ff;
   assign rsp_entry_count    = rsp_count_ff;
   assign rsp_over_threshold = rsp_over_ff;

endmodule

`default_nettype wire
